@@ design/uodc_pkg.sv @@
// Shared types, codes and constants of the ultrasonic obstacle drive controller.
package uodc_pkg;

	localparam int SENSOR_COUNT = 3;
	localparam int SENSOR_W     = 2;
	localparam int STAMP_W      = 16;
	localparam int RANGE_W      = 8;
	localparam int SPEED_W      = 10;
	localparam int DUTY_W       = 11;
	localparam int BYTE_W       = 8;
	localparam int PINS_W       = 4;
	localparam int CFG_INDEX_W  = 1;
	localparam int CFG_DATA_W   = 8;

	// operation codes
	localparam logic [1:0] OP_EDGE   = 2'd0;
	localparam logic [1:0] OP_BYTE   = 2'd1;
	localparam logic [1:0] OP_BUTTON = 2'd2;
	localparam logic [1:0] OP_TICK   = 2'd3;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_FRONT_LIMIT = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SIDE_LIMIT  = 1'd1;

	localparam logic [RANGE_W-1:0] FRONT_LIMIT_RST = 8'd25;
	localparam logic [RANGE_W-1:0] SIDE_LIMIT_RST  = 8'd17;

	// command bytes
	localparam logic [BYTE_W-1:0] CMD_AUTO   = 8'h4D; // 'M'
	localparam logic [BYTE_W-1:0] CMD_MANUAL = 8'h41; // 'A'
	localparam logic [BYTE_W-1:0] CMD_FASTER = 8'h75; // 'u'
	localparam logic [BYTE_W-1:0] CMD_SLOWER = 8'h69; // 'i'
	localparam logic [BYTE_W-1:0] CMD_FWD    = 8'h77; // 'w'
	localparam logic [BYTE_W-1:0] CMD_REV    = 8'h73; // 's'
	localparam logic [BYTE_W-1:0] CMD_LEFT   = 8'h61; // 'a'
	localparam logic [BYTE_W-1:0] CMD_RIGHT  = 8'h64; // 'd'
	localparam logic [BYTE_W-1:0] CMD_HALT   = 8'h6B; // 'k'
	localparam logic [BYTE_W-1:0] CMD_NONE   = 8'h00;

	// bridge pin patterns: left_a, left_b, right_a, right_b
	localparam logic [PINS_W-1:0] PINS_OFF        = 4'b0000;
	localparam logic [PINS_W-1:0] PINS_FWD        = 4'b1010;
	localparam logic [PINS_W-1:0] PINS_REV        = 4'b0101;
	localparam logic [PINS_W-1:0] PINS_LEFT       = 4'b0010;
	localparam logic [PINS_W-1:0] PINS_RIGHT      = 4'b1000;
	localparam logic [PINS_W-1:0] PINS_BRAKE_RGT  = 4'b1011;
	localparam logic [PINS_W-1:0] PINS_BRAKE_LFT  = 4'b1110;

	// speed stepping
	localparam logic [SPEED_W-1:0] SPEED_RST  = 10'd480;
	localparam logic [SPEED_W-1:0] SPEED_STEP = 10'd10;
	localparam logic [SPEED_W:0]   SPEED_MAX  = 11'd1000;
	localparam logic [SPEED_W-1:0] SPEED_CAP  = 10'd999;

	// echo time to cm: divide by 58 = halve, then multiply by ceil(2^18/29)
	localparam logic [STAMP_W-1:0] ECHO_SAT_TICKS = 16'd14848; // 256 * 58
	localparam logic [13:0]        DIV29_MUL      = 14'd9040;
	localparam int                 DIV29_SHIFT    = 18;

	// divide by 10 = halve, then multiply by ceil(2^15/5)
	localparam logic [12:0] DIV5_MUL   = 13'd6554;
	localparam int          DIV5_SHIFT = 15;

	typedef struct packed {
		logic [1:0]          operation;
		logic [SENSOR_W-1:0] sensor;
		logic [STAMP_W-1:0]  timestamp;
		logic [BYTE_W-1:0]   rx_byte;
	} uodc_item_t;

	typedef struct packed {
		logic [PINS_W-1:0]  pins;
		logic [DUTY_W-1:0]  left_duty;
		logic [DUTY_W-1:0]  right_duty;
		logic               auto_mode;
		logic [SPEED_W-1:0] speed_now;
	} uodc_result_t;

endpackage

@@ design/uodc_if.sv @@
// Handshake channels for command items and drive results.
interface uodc_in_if;
	import uodc_pkg::*;
	logic                valid;
	logic                ready;
	logic [1:0]          operation;
	logic [SENSOR_W-1:0] sensor;
	logic [STAMP_W-1:0]  timestamp;
	logic [BYTE_W-1:0]   rx_byte;

	modport source (output valid, output operation, output sensor, output timestamp,
		output rx_byte, input ready);
	modport sink (input valid, input operation, input sensor, input timestamp,
		input rx_byte, output ready);
endinterface

interface uodc_out_if;
	import uodc_pkg::*;
	logic               valid;
	logic               ready;
	logic               left_a;
	logic               left_b;
	logic               right_a;
	logic               right_b;
	logic [DUTY_W-1:0]  left_duty;
	logic [DUTY_W-1:0]  right_duty;
	logic               auto_mode;
	logic [SPEED_W-1:0] speed_now;

	modport source (output valid, output left_a, output left_b, output right_a,
		output right_b, output left_duty, output right_duty, output auto_mode,
		output speed_now, input ready);
	modport sink (input valid, input left_a, input left_b, input right_a,
		input right_b, input left_duty, input right_duty, input auto_mode,
		input speed_now, output ready);
endinterface

@@ design/ultrasonic_obstacle_drive_controller.sv @@
// Ultrasonic obstacle-avoidance drive controller: echo ranging, command decode and drive outputs.
// Each transaction on cmd (echo edge, UART byte, button press or drive tick) yields exactly one
// transaction on res, carrying the H-bridge pin levels, both PWM compare values, the mode and
// the base speed as they stand after that item. An item is held in an input register, updated
// against the state in one pass of short logic, and written to a result register, so one item
// is taken every cycle while res keeps draining; a stalled res holds at most two items (input
// register and result register) before cmd.ready drops. Echo edges come in pairs per sensor:
// the first stores its stamp, the second turns the modulo-65536 difference into centimetres
// (divide by 58, saturate at 255); an edge whose stamp equals the stored one leaves the
// distance as it was. Sensor code 3 is ignored. The user must write the front and side limits
// on the cfg port only while the block is idle; the block itself does not enforce it.
module ultrasonic_obstacle_drive_controller (
	input  logic                               clk,
	input  logic                               arst_n,
	uodc_in_if.sink                            cmd,
	uodc_out_if.source                         res,
	input  logic                               cfg_we,
	input  logic [uodc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [uodc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import uodc_pkg::*;

	// input stage
	uodc_item_t item_s1;
	logic       valid_s1;
	logic       advance;

	// result stage
	uodc_result_t res_q;
	logic         res_valid_q;

	// limits
	logic [RANGE_W-1:0] front_q;
	logic [RANGE_W-1:0] side_q;

	// controller state
	logic [SENSOR_COUNT-1:0] phase_q, phase_d;
	logic [STAMP_W-1:0]      first_q [SENSOR_COUNT];
	logic [STAMP_W-1:0]      first_d [SENSOR_COUNT];
	logic [RANGE_W-1:0]      range_q [SENSOR_COUNT];
	logic [RANGE_W-1:0]      range_d [SENSOR_COUNT];
	logic                    mode_q, mode_d;
	logic [SPEED_W-1:0]      speed_q, speed_d;
	logic [BYTE_W-1:0]       last_cmd_q, last_cmd_d;
	logic [PINS_W-1:0]       pins_q, pins_d;
	logic [DUTY_W-1:0]       left_q, left_d;
	logic [DUTY_W-1:0]       right_q, right_d;

	// datapath terms
	logic [STAMP_W-1:0] first_sel;
	logic               phase_sel;
	logic               sensor_ok;
	logic [STAMP_W-1:0] echo_diff;
	logic [26:0]        echo_prod;
	logic [RANGE_W-1:0] echo_cm;
	logic [SPEED_W:0]   speed_up;
	logic [SPEED_W-1:0] speed_dn;
	logic [13:0]        speed_x11;
	logic [11:0]        speed_x3;
	logic [25:0]        hi_prod;
	logic [23:0]        lo_prod;
	logic [DUTY_W-1:0]  duty_hi;
	logic [DUTY_W-1:0]  duty_lo;
	logic [PINS_W-1:0]  cruise_pins;

	// advance the input register whenever the result register is free or being emptied
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= '{operation: cmd.operation, sensor: cmd.sensor,
				timestamp: cmd.timestamp, rx_byte: cmd.rx_byte};
		end
	end

	// limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= FRONT_LIMIT_RST;
			side_q  <= SIDE_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FRONT_LIMIT: front_q <= cfg_data[RANGE_W-1:0];
				CFG_SIDE_LIMIT:  side_q  <= cfg_data[RANGE_W-1:0];
				default: ;
			endcase
		end
	end

	// pick the addressed sensor's phase and stored stamp
	always_comb begin
		first_sel = '0;
		phase_sel = 1'b0;
		sensor_ok = 1'b0;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			if (item_s1.sensor == SENSOR_W'(i)) begin
				first_sel = first_q[i];
				phase_sel = phase_q[i];
				sensor_ok = 1'b1;
			end
		end
	end

	// echo width to centimetres: floor(diff / 58), saturated at 255
	assign echo_diff = item_s1.timestamp - first_sel;
	assign echo_prod = {14'd0, echo_diff[13:1]} * {13'd0, DIV29_MUL};
	assign echo_cm   = (echo_diff >= ECHO_SAT_TICKS) ? {RANGE_W{1'b1}}
		: echo_prod[DIV29_SHIFT+RANGE_W-1:DIV29_SHIFT];

	// speed stepping
	assign speed_up = {1'b0, speed_q} + {1'b0, SPEED_STEP};
	assign speed_dn = (speed_q < SPEED_STEP) ? '0 : speed_q - SPEED_STEP;

	// avoidance duties: floor(speed * 11 / 10) and floor(speed * 3 / 10)
	assign speed_x11 = {1'b0, speed_q, 3'b000} + {3'b000, speed_q, 1'b0} + {4'b0000, speed_q};
	assign speed_x3  = {1'b0, speed_q, 1'b0} + {2'b00, speed_q};
	assign hi_prod   = {13'd0, speed_x11[13:1]} * {13'd0, DIV5_MUL};
	assign lo_prod   = {13'd0, speed_x3[11:1]} * {11'd0, DIV5_MUL};
	assign duty_hi   = hi_prod[DIV5_SHIFT+DUTY_W-1:DIV5_SHIFT];
	assign duty_lo   = {2'b00, lo_prod[DIV5_SHIFT+8:DIV5_SHIFT]};

	// clear road: forward, braking one wheel when a side is close (third sensor wins)
	always_comb begin
		cruise_pins = PINS_FWD;
		if (range_q[1] < side_q) begin
			cruise_pins = PINS_BRAKE_RGT;
		end
		if (range_q[2] < side_q) begin
			cruise_pins = PINS_BRAKE_LFT;
		end
	end

	// next state for the item in the input register
	always_comb begin
		phase_d    = phase_q;
		first_d    = first_q;
		range_d    = range_q;
		mode_d     = mode_q;
		speed_d    = speed_q;
		last_cmd_d = last_cmd_q;
		pins_d     = pins_q;
		left_d     = left_q;
		right_d    = right_q;
		case (item_s1.operation)
			OP_EDGE: begin
				for (int i = 0; i < SENSOR_COUNT; i++) begin
					if (sensor_ok && item_s1.sensor == SENSOR_W'(i)) begin
						if (!phase_sel) begin
							first_d[i] = item_s1.timestamp;
							phase_d[i] = 1'b1;
						end else begin
							if (item_s1.timestamp != first_sel) begin
								range_d[i] = echo_cm;
							end
							phase_d[i] = 1'b0;
						end
					end
				end
			end
			OP_BYTE: begin
				last_cmd_d = item_s1.rx_byte;
				case (item_s1.rx_byte)
					CMD_AUTO:   mode_d = 1'b1;
					CMD_MANUAL: mode_d = 1'b0;
					CMD_FASTER: speed_d = (speed_up > SPEED_MAX) ? SPEED_CAP
						: speed_up[SPEED_W-1:0];
					CMD_SLOWER: speed_d = speed_dn;
					default: ;
				endcase
			end
			OP_BUTTON: begin
				mode_d = ~mode_q;
			end
			OP_TICK: begin
				if (!mode_q) begin
					case (last_cmd_q)
						CMD_FWD: begin
							pins_d  = PINS_FWD;
							left_d  = {1'b0, speed_q};
							right_d = {1'b0, speed_q};
						end
						CMD_REV: begin
							pins_d  = PINS_REV;
							left_d  = {1'b0, speed_q};
							right_d = {1'b0, speed_q};
						end
						CMD_LEFT: begin
							pins_d  = PINS_LEFT;
							left_d  = {1'b0, speed_q};
							right_d = {1'b0, speed_q};
						end
						CMD_RIGHT: begin
							pins_d  = PINS_RIGHT;
							left_d  = {1'b0, speed_q};
							right_d = {1'b0, speed_q};
						end
						CMD_HALT, CMD_NONE: pins_d = PINS_OFF;
						default: ;
					endcase
				end else if (range_q[0] < front_q) begin
					// obstacle ahead: back off, turning towards the more open side (a tie keeps the duties)
					pins_d = PINS_REV;
					if (range_q[1] > range_q[2]) begin
						left_d  = duty_hi;
						right_d = duty_lo;
					end else if (range_q[1] < range_q[2]) begin
						left_d  = duty_lo;
						right_d = duty_hi;
					end
				end else begin
					pins_d  = cruise_pins;
					left_d  = {1'b0, speed_q};
					right_d = {1'b0, speed_q};
				end
			end
			default: ;
		endcase
	end

	// commit state together with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			mode_q     <= 1'b0;
			speed_q    <= SPEED_RST;
			last_cmd_q <= CMD_NONE;
			pins_q     <= PINS_OFF;
			left_q     <= '0;
			right_q    <= '0;
			for (int i = 0; i < SENSOR_COUNT; i++) begin
				first_q[i] <= '0;
				range_q[i] <= '0;
			end
		end else if (advance) begin
			phase_q    <= phase_d;
			first_q    <= first_d;
			range_q    <= range_d;
			mode_q     <= mode_d;
			speed_q    <= speed_d;
			last_cmd_q <= last_cmd_d;
			pins_q     <= pins_d;
			left_q     <= left_d;
			right_q    <= right_d;
		end
	end

	// result register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= '{pins: pins_d, left_duty: left_d, right_duty: right_d,
				auto_mode: mode_d, speed_now: speed_d};
		end
	end

	assign res.valid      = res_valid_q;
	assign res.left_a     = res_q.pins[3];
	assign res.left_b     = res_q.pins[2];
	assign res.right_a    = res_q.pins[1];
	assign res.right_b    = res_q.pins[0];
	assign res.left_duty  = res_q.left_duty;
	assign res.right_duty = res_q.right_duty;
	assign res.auto_mode  = res_q.auto_mode;
	assign res.speed_now  = res_q.speed_now;

	// base speed never leaves its range
	assert property (@(posedge clk) disable iff (!arst_n) speed_q <= SPEED_MAX[SPEED_W-1:0])
		else $error("base speed above 1000");

	// duties never exceed 110 % of full speed
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.left_duty <= 11'd1100 && res_q.right_duty <= 11'd1100))
		else $error("duty out of range");

	// a driven B input of the left bridge only occurs in reverse or with the left wheel braked
	assert property (@(posedge clk) disable iff (!arst_n)
		pins_q[2] |-> (pins_q == PINS_REV || pins_q == PINS_BRAKE_LFT))
		else $error("illegal bridge pattern");

	// a button press flips the mode
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.operation == OP_BUTTON) |=> mode_q != $past(mode_q))
		else $error("button did not toggle mode");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the ultrasonic obstacle drive controller.
module testbench;
	import uodc_pkg::*;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	uodc_in_if  cmd_ch ();
	uodc_out_if res_ch ();

	ultrasonic_obstacle_drive_controller uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Commands waiting to be offered, and drive results owed by the controller.
	uodc_item_t   cmd_backlog [$];
	uodc_result_t drive_due [$];
	uodc_item_t   head_cmd;
	uodc_result_t drive_seen;
	int unsigned  queued;
	int unsigned  faults;

	// Idling: chance per slot (percent) of starting a burst, and cycles left in a burst.
	int unsigned gap_pct;
	int unsigned stall_pct;
	int unsigned gap_left;
	int unsigned stall_left;

	// Shadow of the controller: echo ranging, mode, speed and drive outputs.
	logic              echo_armed [SENSOR_COUNT];
	logic [STAMP_W-1:0] echo_start [SENSOR_COUNT];
	logic [RANGE_W-1:0] echo_cm [SENSOR_COUNT];
	logic              auto_on;
	int unsigned       base_spd;
	logic [BYTE_W-1:0] last_cmd;
	logic [PINS_W-1:0] bridge;
	int unsigned       duty_l;
	int unsigned       duty_r;
	logic [RANGE_W-1:0] lim_front;
	logic [RANGE_W-1:0] lim_side;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Drive both wheels evenly at the base speed with the given bridge pattern.
	function automatic void run_even(input logic [PINS_W-1:0] pattern);
		bridge = pattern;
		duty_l = base_spd;
		duty_r = base_spd;
	endfunction

	// Apply one accepted command to the shadow state and queue the drive result it owes.
	task automatic advance_controller(input uodc_item_t it);
		logic [STAMP_W-1:0] span;
		logic [PINS_W-1:0]  pattern;
		int unsigned        cm;
		uodc_result_t       owed;
		case (it.operation)
			OP_EDGE: begin
				// sensor code 3 has no channel: drop the edge
				if (it.sensor < SENSOR_COUNT) begin
					if (!echo_armed[it.sensor]) begin
						echo_start[it.sensor] = it.timestamp;
						echo_armed[it.sensor] = 1'b1;
					end else begin
						// equal stamps keep the old distance but still close the pair
						if (it.timestamp != echo_start[it.sensor]) begin
							span = it.timestamp - echo_start[it.sensor];
							cm = span / 58;
							echo_cm[it.sensor] = (cm > 255) ? 8'd255 : RANGE_W'(cm);
						end
						echo_armed[it.sensor] = 1'b0;
					end
				end
			end
			OP_BYTE: begin
				last_cmd = it.rx_byte;
				case (it.rx_byte)
					CMD_AUTO:   auto_on = 1'b1;
					CMD_MANUAL: auto_on = 1'b0;
					CMD_FASTER: base_spd = (base_spd + SPEED_STEP > SPEED_MAX) ?
						SPEED_CAP : base_spd + SPEED_STEP;
					CMD_SLOWER: base_spd = (base_spd < SPEED_STEP) ? 0 : base_spd - SPEED_STEP;
					default: ;
				endcase
			end
			OP_BUTTON: auto_on = !auto_on;
			OP_TICK: begin
				if (!auto_on) begin
					case (last_cmd)
						CMD_FWD:   run_even(PINS_FWD);
						CMD_REV:   run_even(PINS_REV);
						CMD_LEFT:  run_even(PINS_LEFT);
						CMD_RIGHT: run_even(PINS_RIGHT);
						CMD_HALT, CMD_NONE: bridge = PINS_OFF;
						default: ;
					endcase
				end else if (echo_cm[0] < lim_front) begin
					// obstacle ahead: back off and steer towards the clearer side; a tie keeps the duties
					bridge = PINS_REV;
					if (echo_cm[1] > echo_cm[2]) begin
						duty_l = base_spd * 11 / 10;
						duty_r = base_spd * 3 / 10;
					end else if (echo_cm[1] < echo_cm[2]) begin
						duty_l = base_spd * 3 / 10;
						duty_r = base_spd * 11 / 10;
					end
				end else begin
					// clear ahead: brake one wheel when a side is close, third sensor wins
					pattern = PINS_FWD;
					if (echo_cm[1] < lim_side)
						pattern = PINS_BRAKE_RGT;
					if (echo_cm[2] < lim_side)
						pattern = PINS_BRAKE_LFT;
					run_even(pattern);
				end
			end
			default: ;
		endcase
		owed.pins       = bridge;
		owed.left_duty  = DUTY_W'(duty_l);
		owed.right_duty = DUTY_W'(duty_r);
		owed.auto_mode  = auto_on;
		owed.speed_now  = SPEED_W'(base_spd);
		drive_due.push_back(owed);
	endtask

	function automatic void check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			faults++;
		end
	endfunction

	task automatic queue_cmd(input logic [1:0] op, input logic [SENSOR_W-1:0] sensor,
		input logic [STAMP_W-1:0] stamp, input logic [BYTE_W-1:0] code);
		uodc_item_t it;
		it.operation = op;
		it.sensor    = sensor;
		it.timestamp = stamp;
		it.rx_byte   = code;
		cmd_backlog.push_back(it);
		queued++;
	endtask

	// Build random traffic: mostly complete echo pairs and command/tick sequences,
	// with speed runs long enough to hit both ends and some lone edges as noise.
	task automatic queue_random(input int unsigned amount);
		int unsigned        goal;
		int unsigned        pick;
		int unsigned        cm;
		logic [SENSOR_W-1:0] s;
		logic [STAMP_W-1:0] t0;
		logic [STAMP_W-1:0] span;
		logic [BYTE_W-1:0]  code;
		goal = queued + amount;
		while (queued < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				s  = SENSOR_W'($urandom_range(0, 2));
				t0 = STAMP_W'($urandom);
				case ($urandom_range(0, 9))
					0: span = '0;
					1: span = STAMP_W'($urandom);
					2, 3, 4: begin
						// land close to one of the limits
						cm = 32'(pick[0] ? lim_front : lim_side) + $urandom_range(0, 4);
						cm = (cm < 2) ? 0 : cm - 2;
						span = STAMP_W'(cm * 58 + $urandom_range(0, 57));
					end
					default: span = STAMP_W'($urandom_range(0, 260 * 58));
				endcase
				queue_cmd(OP_EDGE, s, t0, BYTE_W'($urandom));
				if ($urandom_range(0, 3) == 0)
					queue_cmd(OP_TICK, SENSOR_W'($urandom), STAMP_W'($urandom),
						BYTE_W'($urandom));
				queue_cmd(OP_EDGE, s, t0 + span, BYTE_W'($urandom));
			end else if (pick < 55) begin
				case ($urandom_range(0, 9))
					0: code = CMD_AUTO;
					1: code = CMD_MANUAL;
					2: code = CMD_FASTER;
					3: code = CMD_SLOWER;
					4: code = CMD_FWD;
					5: code = CMD_REV;
					6: code = CMD_LEFT;
					7: code = CMD_RIGHT;
					8: code = CMD_HALT;
					default: code = CMD_NONE;
				endcase
				queue_cmd(OP_BYTE, SENSOR_W'($urandom), STAMP_W'($urandom), code);
				queue_cmd(OP_TICK, SENSOR_W'($urandom), STAMP_W'($urandom),
					BYTE_W'($urandom));
			end else if (pick < 57) begin
				code = $urandom_range(0, 1) ? CMD_FASTER : CMD_SLOWER;
				repeat ($urandom_range(1, 110))
					queue_cmd(OP_BYTE, SENSOR_W'($urandom), STAMP_W'($urandom), code);
				queue_cmd(OP_TICK, SENSOR_W'($urandom), STAMP_W'($urandom),
					BYTE_W'($urandom));
			end else if (pick < 80) begin
				queue_cmd(OP_TICK, SENSOR_W'($urandom), STAMP_W'($urandom),
					BYTE_W'($urandom));
			end else if (pick < 85) begin
				queue_cmd(OP_BUTTON, SENSOR_W'($urandom), STAMP_W'($urandom),
					BYTE_W'($urandom));
			end else if (pick < 92) begin
				queue_cmd(OP_BYTE, SENSOR_W'($urandom), STAMP_W'($urandom),
					BYTE_W'($urandom));
			end else begin
				// lone edge on any sensor code, knocks pairs out of step
				queue_cmd(OP_EDGE, SENSOR_W'($urandom), STAMP_W'($urandom),
					BYTE_W'($urandom));
			end
		end
	endtask

	// Hold until every queued transaction has gone in and every result has come back.
	task automatic settle();
		do
			@(negedge clk);
		while (cmd_backlog.size() != 0 || cmd_ch.valid || drive_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_limit(input logic [CFG_INDEX_W-1:0] index, input logic [7:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == CFG_FRONT_LIMIT)
			lim_front = value;
		else
			lim_side = value;
	endtask

	// Sender: offer the next command once the previous transaction has completed,
	// inserting idle bursts at random.
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_ch.valid     <= 1'b0;
			cmd_ch.operation <= OP_EDGE;
			cmd_ch.sensor    <= '0;
			cmd_ch.timestamp <= '0;
			cmd_ch.rx_byte   <= '0;
			gap_left         <= 0;
		end else if (!cmd_ch.valid || cmd_ch.ready) begin
			if (gap_left != 0) begin
				gap_left     <= gap_left - 1;
				cmd_ch.valid <= 1'b0;
			end else if ($urandom_range(1, 100) <= gap_pct) begin
				gap_left     <= $urandom_range(0, 16);
				cmd_ch.valid <= 1'b0;
			end else if (cmd_backlog.size() != 0) begin
				head_cmd = cmd_backlog.pop_front();
				cmd_ch.valid     <= 1'b1;
				cmd_ch.operation <= head_cmd.operation;
				cmd_ch.sensor    <= head_cmd.sensor;
				cmd_ch.timestamp <= head_cmd.timestamp;
				cmd_ch.rx_byte   <= head_cmd.rx_byte;
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: predict on every accepted command, check every accepted result
	// against the oldest one owed, and stall the result channel in random bursts.
	// Reset also returns the shadow model to the controller's reset state.
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_left   <= 0;
			faults = 0;
			for (int i = 0; i < SENSOR_COUNT; i++) begin
				echo_armed[i] = 1'b0;
				echo_start[i] = '0;
				echo_cm[i]    = '0;
			end
			auto_on  = 1'b0;
			base_spd = 32'(SPEED_RST);
			last_cmd = CMD_NONE;
			bridge   = PINS_OFF;
			duty_l   = 0;
			duty_r   = 0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready)
				advance_controller({cmd_ch.operation, cmd_ch.sensor, cmd_ch.timestamp,
					cmd_ch.rx_byte});
			if (res_ch.valid && res_ch.ready) begin
				if (drive_due.size() == 0) begin
					$error("drive result with none outstanding");
					faults++;
				end else begin
					drive_seen = drive_due.pop_front();
					check_field("left_a", 16'(drive_seen.pins[3]), 16'(res_ch.left_a));
					check_field("left_b", 16'(drive_seen.pins[2]), 16'(res_ch.left_b));
					check_field("right_a", 16'(drive_seen.pins[1]), 16'(res_ch.right_a));
					check_field("right_b", 16'(drive_seen.pins[0]), 16'(res_ch.right_b));
					check_field("left_duty", 16'(drive_seen.left_duty),
						16'(res_ch.left_duty));
					check_field("right_duty", 16'(drive_seen.right_duty),
						16'(res_ch.right_duty));
					check_field("auto_mode", 16'(drive_seen.auto_mode),
						16'(res_ch.auto_mode));
					check_field("speed_now", 16'(drive_seen.speed_now),
						16'(res_ch.speed_now));
				end
			end
			if (stall_left != 0) begin
				stall_left   <= stall_left - 1;
				res_ch.ready <= 1'b0;
			end else if ($urandom_range(1, 100) <= stall_pct) begin
				stall_left   <= $urandom_range(0, 16);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		// Hold reset and an idle configuration port from the first instant.
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		queued     = 0;
		gap_pct    = 10;
		stall_pct  = 10;
		lim_front  = FRONT_LIMIT_RST;
		lim_side   = SIDE_LIMIT_RST;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: every manual command, byte extremes, echo extremes and both auto paths.
		queue_cmd(OP_TICK, 2'd0, 16'h0000, 8'h00);   // tick straight out of reset
		queue_cmd(OP_BYTE, 2'd3, 16'hFFFF, CMD_FWD);
		queue_cmd(OP_TICK, 2'd1, 16'h5555, 8'hFF);
		queue_cmd(OP_BYTE, 2'd2, 16'hAAAA, CMD_REV);
		queue_cmd(OP_TICK, 2'd0, 16'h0000, 8'h00);
		queue_cmd(OP_BYTE, 2'd0, 16'h0000, CMD_LEFT);
		queue_cmd(OP_TICK, 2'd3, 16'hFFFF, 8'hFF);
		queue_cmd(OP_BYTE, 2'd1, 16'h1234, CMD_RIGHT);
		queue_cmd(OP_TICK, 2'd0, 16'h0000, 8'h00);
		queue_cmd(OP_BYTE, 2'd0, 16'h0000, CMD_HALT);
		queue_cmd(OP_TICK, 2'd0, 16'h0000, 8'h00);
		queue_cmd(OP_BYTE, 2'd3, 16'hFFFF, 8'hFF);   // unknown byte leaves the drive alone
		queue_cmd(OP_TICK, 2'd0, 16'h0000, 8'h00);
		// longest possible echo: saturates at 255 cm
		queue_cmd(OP_EDGE, 2'd0, 16'h0000, 8'hFF);
		queue_cmd(OP_EDGE, 2'd0, 16'hFFFF, 8'h00);
		// echo across the timer wrap: one centimetre
		queue_cmd(OP_EDGE, 2'd1, 16'hFFF0, 8'h00);
		queue_cmd(OP_EDGE, 2'd1, 16'h002A, 8'hFF);
		// equal stamps: distance unchanged, pair closed
		queue_cmd(OP_EDGE, 2'd2, 16'h1234, 8'h00);
		queue_cmd(OP_EDGE, 2'd2, 16'h1234, 8'h00);
		queue_cmd(OP_EDGE, 2'd3, 16'hABCD, 8'h00);   // no such sensor
		queue_cmd(OP_BYTE, 2'd0, 16'h0000, CMD_AUTO);
		queue_cmd(OP_TICK, 2'd0, 16'h0000, 8'h00);   // clear ahead, both sides close
		queue_cmd(OP_EDGE, 2'd0, 16'h0100, 8'h00);
		queue_cmd(OP_EDGE, 2'd0, 16'h01AE, 8'h00);   // 3 cm ahead
		queue_cmd(OP_TICK, 2'd0, 16'h0000, 8'h00);   // reverse and turn
		queue_cmd(OP_BUTTON, 2'd0, 16'h0000, 8'h00);
		queue_cmd(OP_BYTE, 2'd0, 16'h0000, CMD_FASTER);
		queue_cmd(OP_BYTE, 2'd0, 16'h0000, CMD_SLOWER);
		queue_cmd(OP_BYTE, 2'd0, 16'h0000, CMD_MANUAL);
		settle();

		// Random phases, each under its own limits and idling; the last one runs flat out.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					write_limit(CFG_FRONT_LIMIT, 8'd0);
					write_limit(CFG_SIDE_LIMIT, 8'd0);
				end
				1: begin
					write_limit(CFG_FRONT_LIMIT, 8'd255);
					write_limit(CFG_SIDE_LIMIT, 8'd255);
				end
				2: begin
					write_limit(CFG_FRONT_LIMIT, FRONT_LIMIT_RST);
					write_limit(CFG_SIDE_LIMIT, SIDE_LIMIT_RST);
				end
				4: begin
					write_limit(CFG_FRONT_LIMIT, 8'($urandom_range(20, 60)));
					write_limit(CFG_SIDE_LIMIT, 8'($urandom_range(5, 40)));
				end
				default: begin
					write_limit(CFG_FRONT_LIMIT, 8'($urandom));
					write_limit(CFG_SIDE_LIMIT, 8'($urandom));
				end
			endcase
			@(negedge clk);
			case (phase)
				0: begin gap_pct = 10; stall_pct = 10; end
				1: begin gap_pct = 0;  stall_pct = 25; end
				2: begin gap_pct = 25; stall_pct = 0;  end
				3: begin gap_pct = 5;  stall_pct = 5;  end
				4: begin gap_pct = 15; stall_pct = 15; end
				default: begin gap_pct = 0; stall_pct = 0; end
			endcase
			queue_random(200);
			settle();
		end

		repeat (8) @(negedge clk);
		if (faults == 0)
			$display("ultrasonic_obstacle_drive_controller test passed");
		else
			$display("ultrasonic_obstacle_drive_controller test failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#(10_000_000);
		$display("ultrasonic_obstacle_drive_controller test failed");
		$finish;
	end

endmodule
